>>> hw/rtl/pip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg - shared constants for the point-in-polygon ray caster
// Field widths, request codes and fixed-point constants.
// ----------------------------------------------------------------------------
package pip_pkg;

    // word field widths (fixed by the channel format)
    localparam int REQ_TYPE_W    = 1;
    localparam int IDX_FIELD_W   = 4;
    localparam int COORD_FIELD_W = 32;
    localparam int CROSS_W       = 5;

    // vertex_count register
    localparam int VCOUNT_W = 5;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd4;

    // request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_LOAD = 1'b0;
    localparam logic [REQ_TYPE_W-1:0] REQ_TEST = 1'b1;

    // Q16.16: 1.0 nudge applied on a y tie
    localparam int FRAC_W = 16;
    localparam int Q_ONE  = 1 << FRAC_W;

    // digit width of the shared multiplier's narrow operand
    localparam int DIGIT_W = 16;

endpackage

>>> hw/rtl/pip_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_req_if - request channel
// Valid/ready channel carrying vertex loads and point tests.
// ----------------------------------------------------------------------------
interface pip_req_if;
    logic                                    valid;
    logic                                    ready;
    logic [pip_pkg::REQ_TYPE_W-1:0]          req_type;
    logic [pip_pkg::IDX_FIELD_W-1:0]         vertex_index;
    logic signed [pip_pkg::COORD_FIELD_W-1:0] coord_x;
    logic signed [pip_pkg::COORD_FIELD_W-1:0] coord_y;

    modport source (output valid, output req_type, output vertex_index,
                    output coord_x, output coord_y, input ready);
    modport sink   (input valid, input req_type, input vertex_index,
                    input coord_x, input coord_y, output ready);
endinterface

>>> hw/rtl/pip_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_rsp_if - result channel
// Valid/ready channel carrying one test result per point.
// ----------------------------------------------------------------------------
interface pip_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           inside_res;
    logic [pip_pkg::CROSS_W-1:0]    crossing_count;

    modport source (output valid, output inside_res, output crossing_count,
                    input ready);
    modport sink   (input valid, input inside_res, input crossing_count,
                    output ready);
endinterface

>>> hw/rtl/point_in_polygon_ray_cast_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_ray_cast_top - ray-cast point-in-polygon tester
// Vertex table in RAM, edges walked one at a time, exact slope compare on
// one shared signed multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   req  : valid/ready words. req_type REQ_LOAD writes coord_x/coord_y into
//          slot vertex_index (slots at or past MAX_VERTICES are dropped) and
//          gives no result. req_type REQ_TEST casts a +x ray from the point.
//   rsp  : one word per test: crossing_count and inside_res (count is odd).
//   cfg  : cfg_we/cfg_wdata write vertex_count (clamped to MAX_VERTICES);
//          write only while idle.
// Sequence:
//   A load leaves the sequencer idle, so ready stays high.
//   A test walks FIRST, then ORDER and TEST for each edge, then DONE (plus
//   the wait for a free result slot); with no edges it goes straight to
//   DONE. An edge ends at TEST when the bounding checks settle it, else it
//   goes on through MUL and DEC: the multiplier takes one 16-bit digit of
//   a y span per cycle and alternates the two cross products.
//   ready is high only while the sequencer is idle.
// Reset: control clears, vertex_count returns to 4. The vertex table is not
//   cleared; test only after the vertices in use are loaded.
// Stall: the result sits in an output register; a new word is taken while
//   it waits, and a finished test holds until the slot frees up.
// ----------------------------------------------------------------------------
module point_in_polygon_ray_cast_top #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_WIDTH  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pip_pkg::VCOUNT_W-1:0]   cfg_wdata,
    pip_req_if.sink                        req,
    pip_rsp_if.source                      rsp
);

    // ------------------------------------------------------------------
    // derived widths
    // ------------------------------------------------------------------
    localparam int CW     = COORD_WIDTH;
    localparam int IDX_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int NW     = (CNT_W > pip_pkg::VCOUNT_W) ? CNT_W : pip_pkg::VCOUNT_W;
    localparam int SW     = (CNT_W > pip_pkg::IDX_FIELD_W) ? CNT_W : pip_pkg::IDX_FIELD_W;
    // nudged y: needs room for +1.0 above the largest coordinate
    localparam int YW     = (CW >= pip_pkg::FRAC_W + 1) ? CW + 1 : pip_pkg::FRAC_W + 2;
    localparam int ND     = (CW + pip_pkg::DIGIT_W - 1) / pip_pkg::DIGIT_W;
    localparam int PADW   = ND * pip_pkg::DIGIT_W;
    localparam int STEP_W = $clog2(2 * ND);
    localparam int PW     = CW + 1 + pip_pkg::DIGIT_W + 1;
    localparam int AW     = 2 * CW + 3;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FIRST = 7'b0000010,
        S_ORDER = 7'b0000100,
        S_TEST  = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_DEC   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    function automatic logic signed [CW-1:0] to_coord(
        input logic [pip_pkg::COORD_FIELD_W-1:0] f
    );
        logic signed [63:0] ext;
        ext = 64'(signed'(f));
        return ext[CW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t                        state_reg, state_next;
    logic [pip_pkg::VCOUNT_W-1:0]  vcount_reg, vcount_next;
    logic [CNT_W-1:0]              n_reg, n_next;
    logic [CNT_W-1:0]              last_reg, last_next;
    logic [CNT_W-1:0]              edge_reg, edge_next;
    logic [CNT_W-1:0]              rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]              hits_reg, hits_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic                          res_valid_reg, res_valid_next;

    // datapath (no reset)
    logic signed [CW-1:0]          px_reg, py_reg;
    logic signed [CW-1:0]          first_x_reg, first_y_reg;
    logic signed [CW-1:0]          prev_x_reg, prev_y_reg;
    logic signed [CW-1:0]          ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [CW-1:0]          lox_reg, hix_reg;
    logic signed [YW-1:0]          pyr_reg;
    logic signed [CW:0]            d1_reg, d2_reg;
    logic [CW-1:0]                 dyp_reg, dyb_reg;
    logic signed [AW-1:0]          acc_reg;
    logic                          res_inside_reg;
    logic [pip_pkg::CROSS_W-1:0]   res_count_reg;

    // ------------------------------------------------------------------
    // vertex RAM: {x, y}
    // ------------------------------------------------------------------
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [2*CW-1:0]      wr_data;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [2*CW-1:0]      rd_data;

    pip_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_VERTICES)
    ) u_vtx_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // request decode
    // ------------------------------------------------------------------
    logic                  req_fire;
    logic signed [CW-1:0]  in_x, in_y;
    logic [NW-1:0]         n_ext;
    logic [CNT_W-1:0]      n_clamp;
    logic                  slot_ok;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign in_x      = to_coord(req.coord_x);
    assign in_y      = to_coord(req.coord_y);

    // vertex_count above the table depth uses the whole table
    assign n_ext   = (NW'(vcount_reg) > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES)
                                                           : NW'(vcount_reg);
    assign n_clamp = CNT_W'(n_ext);
    assign slot_ok = SW'(req.vertex_index) < SW'(MAX_VERTICES);

    assign wr_en   = req_fire && (req.req_type == pip_pkg::REQ_LOAD) && slot_ok;
    assign wr_addr = IDX_W'(req.vertex_index);
    assign wr_data = {in_x, in_y};

    // one read in flight ahead of the edge that needs it
    logic rd_issue;
    assign rd_issue = ((state_reg == S_FIRST) || (state_reg == S_ORDER))
                      && (rd_ptr_reg < n_reg);
    assign rd_en    = (req_fire && (req.req_type == pip_pkg::REQ_TEST)) || rd_issue;
    assign rd_addr  = rd_issue ? rd_ptr_reg[IDX_W-1:0] : '0;

    // ------------------------------------------------------------------
    // ORDER: pick current endpoint, sort by y, nudge y on a tie
    // ------------------------------------------------------------------
    logic signed [CW-1:0]  rd_x, rd_y, cur_x, cur_y;
    logic signed [CW-1:0]  ax_c, ay_c, bx_c, by_c, lox_c, hix_c;
    logic signed [YW-1:0]  py_ext, pyr_c;
    logic                  prev_lower, y_tie;

    assign rd_x  = rd_data[2*CW-1:CW];
    assign rd_y  = rd_data[CW-1:0];
    // closing edge wraps to vertex 0
    assign cur_x = (edge_reg == last_reg) ? first_x_reg : rd_x;
    assign cur_y = (edge_reg == last_reg) ? first_y_reg : rd_y;

    // A is the lower endpoint; on equal y A is the second endpoint
    assign prev_lower = prev_y_reg < cur_y;
    assign ax_c  = prev_lower ? prev_x_reg : cur_x;
    assign ay_c  = prev_lower ? prev_y_reg : cur_y;
    assign bx_c  = prev_lower ? cur_x : prev_x_reg;
    assign by_c  = prev_lower ? cur_y : prev_y_reg;
    assign lox_c = (prev_x_reg < cur_x) ? prev_x_reg : cur_x;
    assign hix_c = (prev_x_reg < cur_x) ? cur_x : prev_x_reg;

    assign y_tie  = (py_reg == prev_y_reg) || (py_reg == cur_y);
    assign py_ext = {{(YW-CW){py_reg[CW-1]}}, py_reg};
    assign pyr_c  = py_ext + (y_tie ? YW'(pip_pkg::Q_ONE) : YW'(0));

    // ------------------------------------------------------------------
    // TEST: bounding checks, spans for the slope compare
    // ------------------------------------------------------------------
    logic signed [YW-1:0]  ay_ext, by_ext, dyp_full;
    logic signed [CW:0]    d1_c, d2_c, dyb_full;
    logic                  y_out, x_right, x_left, on_a;
    logic                  early_done, early_hit;

    assign ay_ext  = {{(YW-CW){ay_reg[CW-1]}}, ay_reg};
    assign by_ext  = {{(YW-CW){by_reg[CW-1]}}, by_reg};
    assign y_out   = (pyr_reg < ay_ext) || (pyr_reg > by_ext);
    assign x_right = px_reg >= hix_reg;
    assign x_left  = px_reg < lox_reg;
    assign on_a    = px_reg == ax_reg;   // straight above A: infinite slope

    assign early_done = y_out || x_right || x_left || on_a;
    assign early_hit  = !y_out && !x_right && (x_left || on_a);

    assign d1_c     = {px_reg[CW-1], px_reg} - {ax_reg[CW-1], ax_reg};
    assign d2_c     = {bx_reg[CW-1], bx_reg} - {ax_reg[CW-1], ax_reg};
    assign dyp_full = pyr_reg - ay_ext;
    assign dyb_full = {by_reg[CW-1], by_reg} - {ay_reg[CW-1], ay_reg};

    // ------------------------------------------------------------------
    // MUL: D = dyp*d2 - dyb*d1, MSB digit first, one product per cycle
    // ------------------------------------------------------------------
    logic                        even_step;
    logic [STEP_W-1:0]           dig_sel;
    logic [PADW-1:0]             dyp_pad, dyb_pad;
    logic [pip_pkg::DIGIT_W-1:0] mul_b;
    logic signed [CW:0]          mul_a;
    logic signed [PW-1:0]        prod;
    logic signed [AW-1:0]        prod_ext, acc_c;

    assign even_step = !step_reg[0];
    assign dig_sel   = STEP_W'(ND - 1) - (step_reg >> 1);
    assign dyp_pad   = PADW'(dyp_reg);
    assign dyb_pad   = PADW'(dyb_reg);
    assign mul_a     = even_step ? d2_reg : d1_reg;
    assign mul_b     = even_step
                       ? pip_pkg::DIGIT_W'(dyp_pad >> (dig_sel * pip_pkg::DIGIT_W))
                       : pip_pkg::DIGIT_W'(dyb_pad >> (dig_sel * pip_pkg::DIGIT_W));
    assign prod      = mul_a * $signed({1'b0, mul_b});
    assign prod_ext  = {{(AW-PW){prod[PW-1]}}, prod};
    assign acc_c     = even_step ? ((acc_reg <<< pip_pkg::DIGIT_W) + prod_ext)
                                 : (acc_reg - prod_ext);

    // DEC: with d2 > 0 crossed when D >= 0; with d2 < 0 when D <= 0
    logic dec_hit;
    assign dec_hit = d2_reg[CW] ? (acc_reg[AW-1] || (acc_reg == '0))
                                : !acc_reg[AW-1];

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    logic edge_fin, edge_hit, res_load;

    always_comb
    begin
        state_next     = state_reg;
        vcount_next    = vcount_reg;
        n_next         = n_reg;
        last_next      = last_reg;
        edge_next      = edge_reg;
        rd_ptr_next    = rd_ptr_reg;
        hits_next      = hits_reg;
        step_next      = step_reg;
        res_valid_next = res_valid_reg;
        edge_fin       = 1'b0;
        edge_hit       = 1'b0;
        res_load       = 1'b0;

        if (cfg_we)
        begin
            vcount_next = cfg_wdata;
        end

        if (rsp.valid && rsp.ready)
        begin
            res_valid_next = 1'b0;
        end

        if (rd_issue)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire && (req.req_type == pip_pkg::REQ_TEST))
                begin
                    hits_next   = '0;
                    edge_next   = '0;
                    n_next      = n_clamp;
                    last_next   = n_clamp - 1'b1;
                    rd_ptr_next = CNT_W'(1);
                    state_next  = (n_clamp == '0) ? S_DONE : S_FIRST;
                end
            end
            S_FIRST:
            begin
                state_next = S_ORDER;
            end
            S_ORDER:
            begin
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (early_done)
                begin
                    edge_fin = 1'b1;
                    edge_hit = early_hit;
                end
                else
                begin
                    step_next  = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(2 * ND - 1))
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                edge_fin = 1'b1;
                edge_hit = dec_hit;
            end
            S_DONE:
            begin
                if (!res_valid_reg || rsp.ready)
                begin
                    res_load       = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (edge_fin)
        begin
            hits_next = hits_reg + CNT_W'(edge_hit);
            if (edge_reg == last_reg)
            begin
                state_next = S_DONE;
            end
            else
            begin
                edge_next  = edge_reg + 1'b1;
                state_next = S_ORDER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vcount_reg    <= pip_pkg::VCOUNT_RESET;
            n_reg         <= '0;
            last_reg      <= '0;
            edge_reg      <= '0;
            rd_ptr_reg    <= '0;
            hits_reg      <= '0;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vcount_reg    <= vcount_next;
            n_reg         <= n_next;
            last_reg      <= last_next;
            edge_reg      <= edge_next;
            rd_ptr_reg    <= rd_ptr_next;
            hits_reg      <= hits_next;
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            px_reg <= in_x;
            py_reg <= in_y;
        end
        if (state_reg == S_FIRST)
        begin
            first_x_reg <= rd_x;
            first_y_reg <= rd_y;
            prev_x_reg  <= rd_x;
            prev_y_reg  <= rd_y;
        end
        if (state_reg == S_ORDER)
        begin
            ax_reg      <= ax_c;
            ay_reg      <= ay_c;
            bx_reg      <= bx_c;
            by_reg      <= by_c;
            lox_reg     <= lox_c;
            hix_reg     <= hix_c;
            pyr_reg     <= pyr_c;
            prev_x_reg  <= cur_x;
            prev_y_reg  <= cur_y;
        end
        if (state_reg == S_TEST)
        begin
            d1_reg  <= d1_c;
            d2_reg  <= d2_c;
            dyp_reg <= dyp_full[CW-1:0];
            dyb_reg <= dyb_full[CW-1:0];
            acc_reg <= '0;
        end
        if (state_reg == S_MUL)
        begin
            acc_reg <= acc_c;
        end
        if (res_load)
        begin
            res_inside_reg <= hits_reg[0];
            res_count_reg  <= pip_pkg::CROSS_W'(hits_reg);
        end
    end

    assign rsp.valid          = res_valid_reg;
    assign rsp.inside_res     = res_inside_reg;
    assign rsp.crossing_count = res_count_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_prefetch_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ORDER) |->
            (((CNT_W+1)'(rd_ptr_reg) == (CNT_W+1)'(edge_reg) + (CNT_W+1)'(2))
             || (rd_ptr_reg == n_reg)))
        else $error("vertex prefetch out of step with edge walk");

    a_hits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ORDER) |-> (hits_reg <= edge_reg))
        else $error("more crossings than edges tested");

    a_done_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (hits_reg <= n_reg))
        else $error("crossing count exceeds edge count");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == S_DONE))
        else $error("result word raised outside completion");

endmodule

>>> hw/rtl/pip_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pip_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> tb/sv/point_in_polygon_ray_cast_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_ray_cast_top_tb - self-checking bench for the ray caster
// Loads polygons into the vertex table, tests points against them and checks
// every result word against an in-bench crossing counter. Sender bursts and
// receiver stalls are random; vertex_count is rewritten between phases while
// the block is quiet.
// ----------------------------------------------------------------------------
module point_in_polygon_ray_cast_top_tb;
    import pip_pkg::*;

    localparam int MAX_VERTS   = 16;
    localparam int ITEM_TARGET = 500;
    // settle time before a vertex_count register write
    localparam int LOAD_SETTLE = 16;
    // settle time before the end of the run, with slack for a stray result
    localparam int END_SETTLE  = 250;
    localparam int HOLD_CYCLES = 400;
    localparam longint TIMEOUT_NS = 64'd8_000_000;

    localparam logic signed [COORD_FIELD_W-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_FIELD_W-1:0] C_MAX = 32'sh7FFF_FFFF;

    // coordinate spread of one phase
    typedef enum int { SPAN_GRID, SPAN_LOCAL, SPAN_FULL } span_t;

    typedef struct {
        logic [REQ_TYPE_W-1:0]           kind;
        logic [IDX_FIELD_W-1:0]          slot;
        logic signed [COORD_FIELD_W-1:0] x;
        logic signed [COORD_FIELD_W-1:0] y;
    } word_t;

    typedef struct {
        logic               in_poly;
        logic [CROSS_W-1:0] crossings;
    } verdict_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [VCOUNT_W-1:0] cfg_wdata;

    pip_req_if req_ch ();
    pip_rsp_if rsp_ch ();

    point_in_polygon_ray_cast_top #(
        .MAX_VERTICES (MAX_VERTS),
        .COORD_WIDTH  (COORD_FIELD_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // ------------------------------------------------------------------------
    // Shadow of the block: vertex table and vertex_count as seen by accepted
    // words. Updated by the driver at the handshake and by cfg writes.
    // ------------------------------------------------------------------------
    longint              vx_tab [MAX_VERTS];
    longint              vy_tab [MAX_VERTS];
    logic [VCOUNT_W-1:0] vcount_reg;

    word_t    word_q[$];        // words waiting for the driver
    verdict_t verdict_q[$];     // results owed by the block, oldest first
    int       fail_count;

    // stimulus-side view of the table, used to stay inside loaded slots and
    // to aim test points at vertex coordinates
    logic signed [COORD_FIELD_W-1:0] plan_x [MAX_VERTS];
    logic signed [COORD_FIELD_W-1:0] plan_y [MAX_VERTS];
    bit                              plan_loaded [MAX_VERTS];
    int                              words_planned;

    // Does a +x ray from (px, py) cross the edge (x1,y1)-(x2,y2)?
    // Lower endpoint is "a" (second endpoint wins a y tie). A point y on an
    // endpoint y is raised by 1.0 once; longint keeps the extra bit.
    function automatic bit ray_hits_edge(longint px, longint py,
                                         longint x1, longint y1,
                                         longint x2, longint y2);
        longint ax, ay, bx, by, lo_x, hi_x, run_pt, run_edge;
        logic signed [127:0] rise_pt, rise_edge, lhs, rhs;
        if (y1 < y2)
        begin
            ax = x1; ay = y1; bx = x2; by = y2;
        end
        else
        begin
            ax = x2; ay = y2; bx = x1; by = y1;
        end
        lo_x = (ax < bx) ? ax : bx;
        hi_x = (ax < bx) ? bx : ax;
        if (py == ay || py == by)
            py = py + Q_ONE;
        if (py < ay || py > by)
            return 1'b0;
        if (px >= hi_x)
            return 1'b0;
        if (px < lo_x)
            return 1'b1;
        // lo_x <= px < hi_x: edge is not vertical
        run_pt = px - ax;
        if (run_pt == 0)
            return 1'b1;            // straight above the lower end: infinite slope
        run_edge = bx - ax;
        if (run_edge < 0)
        begin
            run_pt   = -run_pt;
            run_edge = -run_edge;
        end
        // point slope >= edge slope, cross-multiplied, all terms positive
        rise_pt   = py - ay;
        rise_edge = by - ay;
        lhs = rise_pt * run_edge;
        rhs = rise_edge * run_pt;
        return lhs >= rhs;
    endfunction

    // Crossing count over the edges in use; count clamps at the table size.
    function automatic verdict_t count_crossings(longint px, longint py);
        int       n, k, hits;
        verdict_t v;
        n    = (int'(vcount_reg) > MAX_VERTS) ? MAX_VERTS : int'(vcount_reg);
        hits = 0;
        for (int j = 0; j < n; j++)
        begin
            k = (j + 1 == n) ? 0 : j + 1;
            if (ray_hits_edge(px, py, vx_tab[j], vy_tab[j], vx_tab[k], vy_tab[k]))
                hits++;
        end
        v.in_poly   = hits[0];
        v.crossings = CROSS_W'(hits);
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Driver: pops words from word_q, sends them in bursts with random gaps.
    // A held word stays on the bus until ready. Each accepted word goes
    // through the shadow right at the handshake.
    // ------------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        word_t w;
        logic  offer;
        if (!rst_n)
        begin
            req_ch.valid        <= 1'b0;
            req_ch.req_type     <= REQ_LOAD;
            req_ch.vertex_index <= '0;
            req_ch.coord_x      <= '0;
            req_ch.coord_y      <= '0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                if (req_ch.req_type == REQ_LOAD)
                begin
                    vx_tab[req_ch.vertex_index] = longint'(req_ch.coord_x);
                    vy_tab[req_ch.vertex_index] = longint'(req_ch.coord_y);
                end
                else
                    verdict_q.insert(verdict_q.size(),
                                     count_crossings(longint'(req_ch.coord_x),
                                                     longint'(req_ch.coord_y)));
            end
            // bus is free when nothing is offered or the offer just went in
            if (!req_ch.valid || req_ch.ready)
            begin
                offer = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (word_q.size() > 0)
                begin
                    w = word_q.pop_front();
                    req_ch.req_type     <= w.kind;
                    req_ch.vertex_index <= w.slot;
                    req_ch.coord_x      <= w.x;
                    req_ch.coord_y      <= w.y;
                    offer = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        // zero gap a third of the time: back-to-back bursts
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                req_ch.valid <= offer;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each result word against the oldest verdict and drives
    // rsp ready. Stall mode changes whenever rx_tick wraps; twice it holds off for
    // HOLD_CYCLES while plenty of words are queued, so the output register
    // fills and the block stops taking words.
    // ------------------------------------------------------------------------
    logic [5:0] rx_tick;
    int         stall_mode;
    int         hold_left;
    int         holds_done;
    int         results_seen;

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        logic     take;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rx_tick      <= '0;
            stall_mode   = 0;
            hold_left    = 0;
            holds_done   = 0;
            results_seen = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                if (verdict_q.size() == 0)
                begin
                    $error("result word with none expected: inside_res %0b crossing_count %0d",
                           rsp_ch.inside_res, rsp_ch.crossing_count);
                    fail_count++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (rsp_ch.inside_res !== want.in_poly)
                    begin
                        $error("inside_res: expected %0b, actual %0b",
                               want.in_poly, rsp_ch.inside_res);
                        fail_count++;
                    end
                    if (rsp_ch.crossing_count !== want.crossings)
                    begin
                        $error("crossing_count: expected %0d, actual %0d",
                               want.crossings, rsp_ch.crossing_count);
                        fail_count++;
                    end
                end
            end

            if (rx_tick == '0)
                stall_mode = $urandom_range(0, 3);
            rx_tick <= rx_tick + 1'b1;

            if (hold_left > 0)
            begin
                hold_left--;
                take = 1'b0;
            end
            else if (holds_done < 2 && word_q.size() > 20 &&
                     results_seen >= ((holds_done == 0) ? 20 : 120))
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
                take = 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0:       take = 1'b1;
                    1:       take = 1'($urandom_range(0, 1));
                    2:       take = ($urandom_range(0, 3) == 0);
                    default: take = rx_tick[3];
                endcase
            end
            rsp_ch.ready <= take;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_load(logic [IDX_FIELD_W-1:0] slot,
                              logic signed [COORD_FIELD_W-1:0] x,
                              logic signed [COORD_FIELD_W-1:0] y);
        word_t w;
        w.kind = REQ_LOAD;
        w.slot = slot;
        w.x    = x;
        w.y    = y;
        word_q.insert(word_q.size(), w);
        plan_x[slot]      = x;
        plan_y[slot]      = y;
        plan_loaded[slot] = 1'b1;
        words_planned++;
    endtask

    task automatic queue_test(logic signed [COORD_FIELD_W-1:0] x,
                              logic signed [COORD_FIELD_W-1:0] y);
        word_t w;
        w.kind = REQ_TEST;
        w.slot = IDX_FIELD_W'($urandom);   // don't-care for a test
        w.x    = x;
        w.y    = y;
        word_q.insert(word_q.size(), w);
        words_planned++;
    endtask

    // Hold the sender until the block has gone quiet: nothing queued, nothing
    // on the bus, no result owed, then a settle time.
    task automatic drain(int settle);
        do
            @(posedge clk);
        while (word_q.size() != 0 || req_ch.valid || verdict_q.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_vertex_count(logic [VCOUNT_W-1:0] value);
        drain(LOAD_SETTLE);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        vcount_reg = value;
    endtask

    function automatic logic signed [COORD_FIELD_W-1:0] pick_coord(span_t span);
        int g;
        case (span)
            SPAN_GRID:
            begin
                // whole units in a small box: y ties are frequent
                g = $urandom_range(0, 16);
                return (g - 8) * Q_ONE;
            end
            SPAN_LOCAL: return $signed($urandom) >>> 9;
            default:    return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        int                              phase_no, used, n_tests, s;
        logic [VCOUNT_W-1:0]             cnt;
        span_t                           span;
        logic signed [COORD_FIELD_W-1:0] px, py;

        // every block input known from time zero
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_LOAD;
        req_ch.vertex_index = '0;
        req_ch.coord_x      = '0;
        req_ch.coord_y      = '0;
        rsp_ch.ready        = 1'b0;
        vcount_reg          = VCOUNT_RESET;
        fail_count          = 0;
        words_planned       = 0;
        for (int i = 0; i < MAX_VERTS; i++)
        begin
            vx_tab[i]      = 0;
            vy_tab[i]      = 0;
            plan_loaded[i] = 1'b0;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: 10x10 square at the reset count of four
        queue_load(0, 0, 0);
        queue_load(1, 10 * Q_ONE, 0);
        queue_load(2, 10 * Q_ONE, 10 * Q_ONE);
        queue_load(3, 0, 10 * Q_ONE);
        queue_test(5 * Q_ONE, 5 * Q_ONE);      // plain inside
        queue_test(5 * Q_ONE, 0);              // on bottom y: raised into square
        queue_test(5 * Q_ONE, 10 * Q_ONE);     // on top y: raised out of it
        queue_test(20 * Q_ONE, 5 * Q_ONE);     // right of everything
        queue_test(-5 * Q_ONE, 5 * Q_ONE);     // left: both vertical edges

        // --- directed: triangle spanning the full coordinate range
        write_vertex_count(5'd3);
        queue_load(0, C_MIN, C_MIN);
        queue_load(1, C_MAX, C_MIN);
        queue_load(2, 0, C_MAX);
        queue_test(0, 0);
        queue_test(C_MIN, 5 * Q_ONE);          // straight above a lower endpoint
        queue_test(32'sh4000_0000, 0);         // needs the slope compare
        queue_test(C_MAX, C_MAX);
        queue_test(C_MIN, C_MIN);              // raise past the top of a flat edge

        // --- directed: degenerate counts
        write_vertex_count(5'd0);              // no edges at all
        queue_test(0, 0);
        write_vertex_count(5'd1);              // single edge back to itself
        queue_test(C_MIN, C_MIN);
        write_vertex_count(5'd2);              // same edge walked both ways
        queue_load(1, 0, 5 * Q_ONE);
        queue_test(-Q_ONE, 0);

        // --- random phases: new count, (re)load the polygon, then tests
        phase_no = 0;
        while (words_planned < ITEM_TARGET)
        begin
            case (phase_no)
                0: cnt = 5'd16;
                1: cnt = 5'd31;                // clamps to the table size
                2: cnt = 5'd3;
                default:
                begin
                    s = $urandom_range(0, 9);
                    if (s < 8)
                        cnt = VCOUNT_W'($urandom_range(3, 16));
                    else if (s == 8)
                        cnt = VCOUNT_W'($urandom_range(17, 31));
                    else
                        cnt = VCOUNT_W'($urandom_range(0, 2));
                end
            endcase
            write_vertex_count(cnt);
            used = (int'(cnt) > MAX_VERTS) ? MAX_VERTS : int'(cnt);
            span = span_t'($urandom_range(0, 2));

            for (int v = 0; v < used; v++)
                if (!plan_loaded[v] || $urandom_range(0, 3) != 0)
                    queue_load(IDX_FIELD_W'(v), pick_coord(span), pick_coord(span));

            // two long phases keep the queue deep for the output hold-off
            n_tests = (phase_no == 1 || phase_no == 6) ? 50 : $urandom_range(8, 30);
            for (int t = 0; t < n_tests; t++)
            begin
                // occasional reload of any slot mid-phase
                if ($urandom_range(0, 9) == 0)
                    queue_load(IDX_FIELD_W'($urandom_range(0, MAX_VERTS - 1)),
                               pick_coord(span), pick_coord(span));
                px = pick_coord(span);
                py = pick_coord(span);
                if (used > 0)
                begin
                    s = $urandom_range(0, used - 1);
                    case ($urandom_range(0, 7))
                        0: py = plan_y[s];                         // y tie
                        1: px = plan_x[s];                         // x on a vertex
                        2:
                        begin
                            px = plan_x[s];
                            py = plan_y[s] + Q_ONE;
                        end
                        3: py = plan_y[s] - Q_ONE;
                        default: ;
                    endcase
                end
                queue_test(px, py);
            end
            phase_no++;
        end

        drain(END_SETTLE);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
